[rtl/advertising_name_filter_assert.svh]
// assertion macros shared by the advertising name filter rtl
`ifndef ADVERTISING_NAME_FILTER_ASSERT_SVH
`define ADVERTISING_NAME_FILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ANF_ASSERT_IMP(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("anf assertion failed");

// next-cycle implication, checked out of reset
`define ANF_ASSERT_NXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("anf assertion failed");

`endif

[rtl/anf_pkg.sv]
// types and constants of the advertising name filter
package anf_pkg;

    localparam int unsigned MAX_NAME_BYTES = 15;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned NAME_LO_W  = 64;
    localparam int unsigned NAME_HI_W  = 56;
    localparam int unsigned NAME_SLOTS = 16;

    localparam logic [BYTE_W-1:0] AD_TYPE_SHORT_NAME    = 8'h08;
    localparam logic [BYTE_W-1:0] AD_TYPE_COMPLETE_NAME = 8'h09;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NAME_LOW    = 2'd0,
        CFG_NAME_HIGH   = 2'd1,
        CFG_NAME_LENGTH = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_LEN  = 3'd0,
        PH_TYPE = 3'd1,
        PH_SKIP = 3'd2,
        PH_NAME = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    typedef struct packed {
        logic              name_found;
        logic              name_matches;
        logic [LEN_W-1:0]  captured_length;
        logic [ADDR_W-1:0] matched_address;
    } result_t;

endpackage

[rtl/anf_req_if.sv]
// request channel carrying one report byte per transfer
interface anf_req_if;
    logic                         valid;
    logic                         ready;
    logic [anf_pkg::BYTE_W-1:0]   report_byte;
    logic                         last_byte;
    logic [anf_pkg::ADDR_W-1:0]   sender_address;

    modport source (output valid, output report_byte, output last_byte,
                    output sender_address, input ready);
    modport sink   (input valid, input report_byte, input last_byte,
                    input sender_address, output ready);
endinterface

[rtl/anf_rsp_if.sv]
// result channel carrying one filter verdict per report
interface anf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         name_found;
    logic                         name_matches;
    logic [anf_pkg::LEN_W-1:0]    captured_length;
    logic [anf_pkg::ADDR_W-1:0]   matched_address;

    modport source (output valid, output name_found, output name_matches,
                    output captured_length, output matched_address, input ready);
    modport sink   (input valid, input name_found, input name_matches,
                    input captured_length, input matched_address, output ready);
endinterface

[rtl/anf_cfg_if.sv]
// configuration write channel
interface anf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [anf_pkg::CFG_IDX_W-1:0]    index;
    logic [anf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/advertising_name_filter.sv]
// advertising report local name filter, top level
// Takes one advertising report byte per cycle on req, the final (RSSI) byte flagged by
// last_byte, walks the length/type structures and captures the first shortened or
// complete local name (up to MAX_NAME_BYTES bytes). On the last byte one result goes out
// on rsp: name found, prefix match against the configured name, captured length, and
// the sender address when matched. Throughput is one byte per cycle while req.ready is high;
// the parse state updates in the accepting cycle and the verdict goes to the output register,
// or to the skid register behind it while a verdict waits there, so bytes are still taken;
// req.ready drops only when both hold an untaken verdict. Configuration writes are always
// ready and take effect on the next byte.
`include "advertising_name_filter_assert.svh"

module advertising_name_filter (
    input  logic         clk,
    input  logic         rst_n,
    anf_req_if.sink      req,
    anf_rsp_if.source    rsp,
    anf_cfg_if.sink      cfg
);

    // configuration registers
    logic [anf_pkg::NAME_LO_W-1:0] name_low_reg;
    logic [anf_pkg::NAME_HI_W-1:0] name_high_reg;
    logic [anf_pkg::LEN_W-1:0]     name_len_reg;

    // parse state
    anf_pkg::phase_t               phase_reg, phase_next;
    logic [anf_pkg::BYTE_W-1:0]    field_len_reg, field_len_next;
    logic [anf_pkg::BYTE_W-1:0]    left_reg, left_next;
    logic [anf_pkg::LEN_W-1:0]     count_reg, count_next;
    logic                          prefix_eq_reg, prefix_eq_next;
    logic                          found_reg, found_next;

    // output register and skid stage
    anf_pkg::result_t              out_reg, skid_reg;
    logic                          out_valid_reg, skid_valid_reg;
    anf_pkg::result_t              result;

    logic                          req_fire;
    logic                          rsp_fire;
    logic                          push;
    logic                          is_name_type;
    logic [anf_pkg::BYTE_W-1:0]    len_m1;
    logic [anf_pkg::BYTE_W-1:0]    name_n;
    logic [anf_pkg::BYTE_W-1:0]    left_dec;
    logic [anf_pkg::BYTE_W-1:0]    exp_bytes [anf_pkg::NAME_SLOTS];
    logic                          byte_miss;
    logic                          match;

    assign req_fire = req.valid && req.ready;
    assign rsp_fire = out_valid_reg && rsp.ready;
    assign push     = req_fire && req.last_byte;
    assign req.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_low_reg  <= '0;
            name_high_reg <= '0;
            name_len_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                anf_pkg::CFG_NAME_LOW:
                    name_low_reg <= cfg.data;
                anf_pkg::CFG_NAME_HIGH:
                    name_high_reg <= cfg.data[anf_pkg::NAME_HI_W-1:0];
                anf_pkg::CFG_NAME_LENGTH:
                    name_len_reg <= cfg.data[anf_pkg::LEN_W-1:0];
                default:
                    ; // unmapped index, write dropped
            endcase
        end
    end

    // expected name as a byte table; the spare top slot reads zero
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            exp_bytes[i] = name_low_reg[i*8 +: 8];
        for (int i = 0; i < 7; i++)
            exp_bytes[8+i] = name_high_reg[i*8 +: 8];
        exp_bytes[anf_pkg::NAME_SLOTS-1] = '0;
    end

    // ---------------- per-byte decode ----------------
    assign is_name_type = (req.report_byte == anf_pkg::AD_TYPE_SHORT_NAME) ||
                          (req.report_byte == anf_pkg::AD_TYPE_COMPLETE_NAME);
    assign len_m1   = field_len_reg - 8'd1;
    // name payload clamped to the capture window
    assign name_n   = (len_m1 > anf_pkg::BYTE_W'(anf_pkg::MAX_NAME_BYTES)) ?
                      anf_pkg::BYTE_W'(anf_pkg::MAX_NAME_BYTES) : len_m1;
    assign left_dec = left_reg - 8'd1;
    // a mismatch only counts inside the expected prefix
    assign byte_miss = (count_reg < name_len_reg) &&
                       (req.report_byte != exp_bytes[count_reg]);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            anf_pkg::PH_LEN:
                if (req.last_byte || req.report_byte == '0)
                    phase_next = anf_pkg::PH_DONE;
                else
                    phase_next = anf_pkg::PH_TYPE;
            anf_pkg::PH_TYPE:
                if (req.last_byte)
                    phase_next = anf_pkg::PH_DONE;
                else if (is_name_type)
                    phase_next = (name_n == '0) ? anf_pkg::PH_DONE : anf_pkg::PH_NAME;
                else
                    phase_next = (len_m1 == '0) ? anf_pkg::PH_LEN : anf_pkg::PH_SKIP;
            anf_pkg::PH_SKIP:
                if (left_dec == '0)
                    phase_next = anf_pkg::PH_LEN;
            anf_pkg::PH_NAME:
                if (left_dec == '0)
                    phase_next = anf_pkg::PH_DONE;
            anf_pkg::PH_DONE:
                phase_next = anf_pkg::PH_DONE;
            default:
                phase_next = anf_pkg::PH_DONE;
        endcase
    end

    // next datapath state
    always_comb
    begin
        field_len_next = field_len_reg;
        left_next      = left_reg;
        count_next     = count_reg;
        prefix_eq_next = prefix_eq_reg;
        found_next     = found_reg;
        unique case (phase_reg)
            anf_pkg::PH_LEN:
                if (!(req.last_byte || req.report_byte == '0))
                    field_len_next = req.report_byte;
            anf_pkg::PH_TYPE:
                if (!req.last_byte)
                begin
                    if (is_name_type)
                    begin
                        found_next     = 1'b1;
                        count_next     = '0;
                        prefix_eq_next = 1'b1;
                        left_next      = name_n;
                    end
                    else
                        left_next = len_m1;
                end
            anf_pkg::PH_SKIP:
                left_next = left_dec;
            anf_pkg::PH_NAME:
            begin
                if (byte_miss)
                    prefix_eq_next = 1'b0;
                count_next = count_reg + 4'd1;
                left_next  = left_dec;
            end
            default:
                ;
        endcase
    end

    // verdict from the state this byte leaves behind
    assign match = found_next && prefix_eq_next && (count_next >= name_len_reg);
    assign result.name_found      = found_next;
    assign result.name_matches    = match;
    assign result.captured_length = count_next;
    assign result.matched_address = match ? req.sender_address : '0;

    // parse state update, rearmed after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= anf_pkg::PH_LEN;
            field_len_reg <= '0;
            left_reg      <= '0;
            count_reg     <= '0;
            prefix_eq_reg <= 1'b1;
            found_reg     <= 1'b0;
        end
        else if (req_fire)
        begin
            if (req.last_byte)
            begin
                phase_reg     <= anf_pkg::PH_LEN;
                field_len_reg <= '0;
                left_reg      <= '0;
                count_reg     <= '0;
                prefix_eq_reg <= 1'b1;
                found_reg     <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                field_len_reg <= field_len_next;
                left_reg      <= left_next;
                count_reg     <= count_next;
                prefix_eq_reg <= prefix_eq_next;
                found_reg     <= found_next;
            end
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // req is stalled here, so no new verdict arrives
            if (rsp_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !rsp.ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (rsp_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (rsp_fire)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !rsp.ready)
                skid_reg <= result;
            else
                out_reg <= result;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.name_found      = out_reg.name_found;
    assign rsp.name_matches    = out_reg.name_matches;
    assign rsp.captured_length = out_reg.captured_length;
    assign rsp.matched_address = out_reg.matched_address;

    // ---------------- checks ----------------
    `ANF_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ANF_ASSERT_IMP(a_no_name_no_count, clk, rst_n, !found_reg, count_reg == '0)
    `ANF_ASSERT_IMP(a_name_left_nonzero, clk, rst_n, phase_reg == anf_pkg::PH_NAME, left_reg != '0)
    `ANF_ASSERT_IMP(a_skip_left_nonzero, clk, rst_n, phase_reg == anf_pkg::PH_SKIP, left_reg != '0)
    `ANF_ASSERT_NXT(a_rearm_after_last, clk, rst_n, push, phase_reg == anf_pkg::PH_LEN && !found_reg)

endmodule
